// File: sv/ssos_pkg.sv
// Shared constants, register codes and the sine table generator for the
// servo sine oscillator with slew limiter. No dependencies.
package ssos_pkg;

  localparam int PHASE_BITS_DEF      = 16;
  localparam int TABLE_ADDR_BITS_DEF = 8;

  localparam int SINE_W   = 15;  // table entries are 0..32767
  localparam int AMP_W    = 7;
  localparam int RATE_W   = 10;
  localparam int ANGLE_W  = 8;
  localparam int ELAPSED_W = 16;
  localparam int CFG_IDX_W = 3;

  localparam int PHASE_STEP_RESET = 983;
  localparam int CENTER_ANGLE     = 90;
  localparam int MAX_ANGLE        = 180;

  // floor(x / 1000) = (x * DIV1000_MUL) >> DIV1000_SHIFT for x < 2^18
  localparam int RATE_PROD_W   = ELAPSED_W + RATE_W;
  localparam int RATE_LOW_W    = 18;
  localparam int DIV1000_MUL_W = 19;
  localparam logic [DIV1000_MUL_W-1:0] DIV1000_MUL = 19'd268436;
  localparam int DIV1000_SHIFT = 28;
  // products at or above this bound limit the step to the full range
  localparam logic [RATE_PROD_W-1:0] RATE_SAT = 26'd181000;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] SERIES_DIV [1:8] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AMPLITUDE    = 3'd0,
    CFG_PHASE_OFFSET = 3'd1,
    CFG_PHASE_STEP   = 3'd2,
    CFG_SLEW_RATE    = 3'd3,
    CFG_STOPPED      = 3'd4
  } cfg_idx_e;

  // Quarter-wave entry i of 2^abits: Q30 Taylor series to the x^17 term,
  // scaled to Q1.15 with round half up. Evaluated at elaboration only.
  function automatic logic [SINE_W-1:0] sine_entry(int unsigned i, int unsigned abits);
    logic [63:0]        x;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        v;
    x    = (HALF_PI_Q30 * 64'(i)) >> abits;
    term = x;
    sum  = $signed(x);
    for (int k = 1; k <= 8; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / SERIES_DIV[k];
      if (k % 2 == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    v = ($unsigned(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[SINE_W-1:0];
  endfunction

endpackage

// File: sv/servo_sine_oscillator_slew_top.sv
// Servo angle generator: sine oscillator target, direct commands, slew limiter.
// Depends on ssos_pkg (constants, register codes, sine table generator).
//
// Usage
//   Input channel (in_valid_i/in_ready_o) carries one transaction per servo
//   update: kind_i = 0 is an oscillator tick, kind_i = 1 a direct command
//   with target_angle_i. elapsed_ms_i sets the slew bound for that move.
//   Output channel (out_valid_o/out_ready_i) returns exactly one result per
//   input transaction, in order: servo_angle_o, was_limited_o, written_o.
//   Configuration is a write-only port (cfg_we_i, cfg_idx_i, cfg_wdata_i),
//   written while no transaction is in flight.
//   Throughput is one transaction per cycle while the receiver keeps up. A
//   transaction passes the input register, product register (table lookup
//   and both multipliers), target/bound register, then the result register,
//   where the limiter updates the held angle.
//   Reset sets the angle to 90, the phase to 0 and the registers to their
//   defaults (phase step 983, everything else 0); the pipeline is empty.
//   When the receiver stalls, the result register holds and stages behind it
//   fill up; in_ready_o drops only once all stages hold a transaction.
module servo_sine_oscillator_slew_top
  import ssos_pkg::*;
#(
  parameter int PHASE_BITS      = PHASE_BITS_DEF,
  parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [PHASE_BITS-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  kind_i,
  input  logic [ANGLE_W-1:0]    target_angle_i,
  input  logic [ELAPSED_W-1:0]  elapsed_ms_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [ANGLE_W-1:0]    servo_angle_o,
  output logic                  was_limited_o,
  output logic                  written_o
);

  localparam int TABLE_N  = 1 << TABLE_ADDR_BITS;
  localparam int FRAC_W   = PHASE_BITS - 2;
  localparam int EXT_W    = FRAC_W + TABLE_ADDR_BITS;
  localparam int IDX_W    = TABLE_ADDR_BITS + 1;
  localparam int MAG_W    = AMP_W + SINE_W;
  localparam int DIVP_W   = RATE_LOW_W + DIV1000_MUL_W;
  localparam int TGT_W    = ANGLE_W + 2;

  typedef struct packed {
    logic                  skip;
    logic                  kind;
    logic [ANGLE_W-1:0]    target;
    logic [ELAPSED_W-1:0]  elapsed;
    logic [PHASE_BITS-1:0] phase;
  } s1_t;

  typedef struct packed {
    logic                   skip;
    logic                   kind;
    logic [ANGLE_W-1:0]     cmd;
    logic                   neg;
    logic [MAG_W-1:0]       mag;
    logic [RATE_PROD_W-1:0] rate_prod;
  } s2_t;

  typedef struct packed {
    logic               skip;
    logic [ANGLE_W-1:0] target;
    logic [ANGLE_W-1:0] lim;
  } s3_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic               limited;
    logic               written;
  } res_t;

  // configuration registers
  logic [AMP_W-1:0]      amp_q;
  logic [PHASE_BITS-1:0] offset_q;
  logic [PHASE_BITS-1:0] step_q;
  logic [RATE_W-1:0]     slew_q;
  logic                  stopped_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_q     <= '0;
      offset_q  <= '0;
      step_q    <= PHASE_BITS'(PHASE_STEP_RESET);
      slew_q    <= '0;
      stopped_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_AMPLITUDE:    amp_q     <= cfg_wdata_i[AMP_W-1:0];
        CFG_PHASE_OFFSET: offset_q  <= cfg_wdata_i;
        CFG_PHASE_STEP:   step_q    <= cfg_wdata_i;
        CFG_SLEW_RATE:    slew_q    <= cfg_wdata_i[RATE_W-1:0];
        CFG_STOPPED:      stopped_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // quarter-wave table, constant
  logic [SINE_W-1:0] sine_rom [TABLE_N+1];
  for (genvar g = 0; g <= TABLE_N; g++) begin : g_rom
    assign sine_rom[g] = sine_entry(g, TABLE_ADDR_BITS);
  end

  // pipeline handshake
  logic v1_q, v2_q, v3_q, ov_q;
  logic in_acc, ld2, ld3, ld_out;

  assign ld_out     = v3_q && (!ov_q || out_ready_i);
  assign ld3        = v2_q && (!v3_q || ld_out);
  assign ld2        = v1_q && (!v2_q || ld3);
  assign in_ready_o = !v1_q || ld2;
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      v1_q <= in_acc || (v1_q && !ld2);
      v2_q <= ld2 || (v2_q && !ld3);
      v3_q <= ld3 || (v3_q && !ld_out);
      ov_q <= ld_out || (ov_q && !out_ready_i);
    end
  end

  // phase accumulator advances on every tick, stopped or not
  logic [PHASE_BITS-1:0] acc_q, acc_d;
  assign acc_d = (in_acc && !kind_i) ? acc_q + step_q : acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  // stage 1: input register
  s1_t s1_q, s1_d;
  always_comb begin
    s1_d.skip    = !kind_i && stopped_q;
    s1_d.kind    = kind_i;
    s1_d.target  = target_angle_i;
    s1_d.elapsed = elapsed_ms_i;
    s1_d.phase   = acc_q + offset_q;
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
  end

  // stage 2: table lookup, amplitude product, slew product
  logic [1:0]                 quad;
  logic [EXT_W-1:0]           frac_ext;
  logic [TABLE_ADDR_BITS-1:0] tab_i;
  logic [IDX_W-1:0]           tab_idx;
  s2_t                        s2_q, s2_d;

  always_comb begin
    quad     = s1_q.phase[PHASE_BITS-1 -: 2];
    frac_ext = {s1_q.phase[FRAC_W-1:0], {TABLE_ADDR_BITS{1'b0}}};
    tab_i    = frac_ext[EXT_W-1 -: TABLE_ADDR_BITS];
    tab_idx  = quad[0] ? IDX_W'(TABLE_N) - {1'b0, tab_i} : {1'b0, tab_i};

    s2_d.skip      = s1_q.skip;
    s2_d.kind      = s1_q.kind;
    s2_d.cmd       = (s1_q.target > ANGLE_W'(MAX_ANGLE)) ? ANGLE_W'(MAX_ANGLE)
                                                        : s1_q.target;
    s2_d.neg       = quad[1];
    s2_d.mag       = MAG_W'(amp_q) * MAG_W'(sine_rom[tab_idx]);
    s2_d.rate_prod = RATE_PROD_W'(s1_q.elapsed) * RATE_PROD_W'(slew_q);
  end

  always_ff @(posedge clk_i) begin
    if (ld2) begin
      s2_q <= s2_d;
    end
  end

  // stage 3: rounded target and slew bound
  logic [MAG_W:0]             round_sum;
  logic [ANGLE_W-1:0]         deg;
  logic signed [TGT_W-1:0]    osc_tgt;
  logic [ANGLE_W-1:0]         osc_clamped;
  logic [DIVP_W-1:0]          div_prod;
  logic [ANGLE_W-1:0]         quot;
  s3_t                        s3_q, s3_d;

  always_comb begin
    round_sum = {1'b0, s2_q.mag} + (MAG_W+1)'(1 << (SINE_W - 1));
    deg       = ANGLE_W'(round_sum >> SINE_W);
    osc_tgt   = s2_q.neg ? TGT_W'(CENTER_ANGLE) - TGT_W'(deg)
                         : TGT_W'(CENTER_ANGLE) + TGT_W'(deg);
    if (osc_tgt < 0) begin
      osc_clamped = '0;
    end else if (osc_tgt > TGT_W'(MAX_ANGLE)) begin
      osc_clamped = ANGLE_W'(MAX_ANGLE);
    end else begin
      osc_clamped = osc_tgt[ANGLE_W-1:0];
    end

    div_prod = DIVP_W'(s2_q.rate_prod[RATE_LOW_W-1:0]) * DIVP_W'(DIV1000_MUL);
    quot     = div_prod[DIV1000_SHIFT +: ANGLE_W];

    s3_d.skip   = s2_q.skip;
    s3_d.target = s2_q.kind ? s2_q.cmd : osc_clamped;
    if (s2_q.rate_prod >= RATE_SAT) begin
      s3_d.lim = ANGLE_W'(MAX_ANGLE);
    end else if (quot == '0) begin
      s3_d.lim = ANGLE_W'(1);
    end else begin
      s3_d.lim = quot;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld3) begin
      s3_q <= s3_d;
    end
  end

  // stage 4: slew limiter against the held angle, result register
  logic [ANGLE_W-1:0]        cur_q, cur_d;
  logic signed [ANGLE_W:0]   diff;
  logic [ANGLE_W-1:0]        delta_mag;
  res_t                      res_q, res_d;

  always_comb begin
    diff      = $signed({1'b0, s3_q.target}) - $signed({1'b0, cur_q});
    delta_mag = diff[ANGLE_W] ? ANGLE_W'(-diff) : diff[ANGLE_W-1:0];
    cur_d = cur_q;
    res_d.limited = 1'b0;
    res_d.written = 1'b1;
    if (s3_q.skip) begin
      res_d.written = 1'b0;
    end else if (slew_q != '0 && delta_mag > s3_q.lim) begin
      res_d.limited = 1'b1;
      cur_d = diff[ANGLE_W] ? cur_q - s3_q.lim : cur_q + s3_q.lim;
    end else begin
      cur_d = s3_q.target;
    end
    res_d.angle = cur_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= ANGLE_W'(CENTER_ANGLE);
    end else if (ld_out) begin
      cur_q <= cur_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_out) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = ov_q;
  assign servo_angle_o = res_q.angle;
  assign was_limited_o = res_q.limited;
  assign written_o     = res_q.written;

  // checks
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q <= ANGLE_W'(MAX_ANGLE))
    else $error("held angle out of range");

  a_bound_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> (s3_q.lim >= ANGLE_W'(1) && s3_q.lim <= ANGLE_W'(MAX_ANGLE)))
    else $error("slew bound out of range");

  a_limit_needs_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && was_limited_o) |-> (slew_q != '0 && written_o))
    else $error("limited result without an active limiter");

  a_hold_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !written_o) |-> (servo_angle_o == cur_q))
    else $error("stopped tick does not report the held angle");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_ready_i && v1_q && v2_q && v3_q) |-> !in_ready_o)
    else $error("input taken while pipeline is full and stalled");

endmodule

// File: verif/servo_tb_pkg.sv
// Command codes shared by the servo oscillator testbench and its checker.
// No dependencies.
package servo_tb_pkg;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_SET  = 1'b1
  } servo_cmd_e;

endpackage

// File: verif/servo_slew_checker.sv
// Scoreboard for servo_sine_oscillator_slew_top: tracks register writes, predicts
// one result per accepted command and compares results in order.
// Depends on ssos_pkg (register codes, port widths) and servo_tb_pkg.
module servo_slew_checker
  import ssos_pkg::*;
  import servo_tb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]          cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic                 kind_i,
  input  logic [ANGLE_W-1:0]   target_angle_i,
  input  logic [ELAPSED_W-1:0] elapsed_ms_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [ANGLE_W-1:0]   servo_angle_i,
  input  logic                 was_limited_i,
  input  logic                 written_i,
  output int                   fail_cnt_o,
  output int                   outstanding_o
);

  localparam int ANGLE_TOP = 180;
  localparam int MID_ANGLE = 90;

  typedef struct packed {
    logic [7:0] angle;
    logic       limited;
    logic       wrote;
  } servo_result_t;

  logic [14:0]   quarter_sine [0:256];
  servo_result_t servo_results_q [$];

  logic [7:0]  angle_now;
  logic [15:0] phase_acc;
  logic [6:0]  amp_r;
  logic [15:0] phase_off_r;
  logic [15:0] phase_step_r;
  logic [9:0]  slew_rate_r;
  logic        stopped_r;

  // sin(pi/2 * i/256) in Q1.15, Q30 series through the x^17 term
  function automatic logic [14:0] sine_point(int unsigned i);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] v;
    longint      sum;
    x    = (64'd1686629713 * 64'(i)) >> 8;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 8; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[14:0];
  endfunction

  // clamp the target, then step toward it by at most the slew bound
  task automatic move_servo(input int target, input logic [15:0] ms);
    longint unsigned bound;
    int              diff;
    int              span;
    int              pos;
    servo_result_t   r;
    pos       = int'(angle_now);
    r.limited = 1'b0;
    if (target < 0) begin
      target = 0;
    end
    if (target > ANGLE_TOP) begin
      target = ANGLE_TOP;
    end
    if (slew_rate_r != '0) begin
      bound = 64'(ms) * 64'(slew_rate_r) / 64'd1000;
      if (bound < 1) begin
        bound = 1;
      end
      if (bound > ANGLE_TOP) begin
        bound = ANGLE_TOP;
      end
      diff = target - pos;
      span = (diff < 0) ? -diff : diff;
      if (64'(span) > bound) begin
        r.limited = 1'b1;
        pos = (diff < 0) ? pos - int'(bound) : pos + int'(bound);
      end else begin
        pos = target;
      end
    end else begin
      pos = target;
    end
    angle_now = pos[7:0];
    r.angle   = angle_now;
    r.wrote   = 1'b1;
    servo_results_q.push_back(r);
  endtask

  task automatic osc_tick(input logic [15:0] ms);
    logic [15:0]   p;
    logic [8:0]    idx;
    int            s;
    int            prod;
    int            mag;
    int            deg;
    servo_result_t r;
    if (!stopped_r) begin
      p = phase_acc + phase_off_r;
      // quadrant in p[15:14]; table index is the top 8 bits of the rest
      idx = p[14] ? 9'd256 - {1'b0, p[13:6]} : {1'b0, p[13:6]};
      s = int'(quarter_sine[idx]);
      if (p[15]) begin
        s = -s;
      end
      prod = int'(amp_r) * s;
      mag  = (prod < 0) ? -prod : prod;
      deg  = (mag + 16384) >>> 15;
      if (prod < 0) begin
        deg = -deg;
      end
      move_servo(MID_ANGLE + deg, ms);
    end else begin
      r = '{angle: angle_now, limited: 1'b0, wrote: 1'b0};
      servo_results_q.push_back(r);
    end
    phase_acc = phase_acc + phase_step_r;
  endtask

  initial begin
    fail_cnt_o    = 0;
    outstanding_o = 0;
    for (int n = 0; n <= 256; n++) begin
      quarter_sine[n] = sine_point(n);
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : watch
    servo_result_t want;
    if (!rst_ni) begin
      angle_now    = 8'(MID_ANGLE);
      phase_acc    = '0;
      amp_r        = '0;
      phase_off_r  = '0;
      phase_step_r = 16'd983;
      slew_rate_r  = '0;
      stopped_r    = 1'b0;
      servo_results_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_AMPLITUDE:    amp_r        = cfg_wdata_i[6:0];
          CFG_PHASE_OFFSET: phase_off_r  = cfg_wdata_i;
          CFG_PHASE_STEP:   phase_step_r = cfg_wdata_i;
          CFG_SLEW_RATE:    slew_rate_r  = cfg_wdata_i[9:0];
          CFG_STOPPED:      stopped_r    = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (servo_results_q.size() == 0) begin
          $error("unexpected result transaction: servo_angle %0d", servo_angle_i);
          fail_cnt_o = fail_cnt_o + 1;
        end else begin
          want = servo_results_q.pop_front();
          if (servo_angle_i !== want.angle) begin
            $error("servo_angle: expected %0d, got %0d", want.angle, servo_angle_i);
            fail_cnt_o = fail_cnt_o + 1;
          end
          if (was_limited_i !== want.limited) begin
            $error("was_limited: expected %0d, got %0d", want.limited, was_limited_i);
            fail_cnt_o = fail_cnt_o + 1;
          end
          if (written_i !== want.wrote) begin
            $error("written: expected %0d, got %0d", want.wrote, written_i);
            fail_cnt_o = fail_cnt_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (servo_cmd_e'(kind_i) == CMD_SET) begin
          move_servo(int'(target_angle_i), elapsed_ms_i);
        end else begin
          osc_tick(elapsed_ms_i);
        end
      end
    end
    outstanding_o = servo_results_q.size();
  end

endmodule

// File: verif/tb.sv
// Testbench top for servo_sine_oscillator_slew_top: clock, reset, register setup,
// directed and random commands with random gaps and stalls, final verdict.
// Depends on ssos_pkg, servo_tb_pkg and servo_slew_checker.
module tb;
  import ssos_pkg::*;
  import servo_tb_pkg::*;

  localparam int CYCLE_LIMIT = 500000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [15:0]          cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 kind_i;
  logic [ANGLE_W-1:0]   target_angle_i;
  logic [ELAPSED_W-1:0] elapsed_ms_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [ANGLE_W-1:0]   servo_angle_o;
  logic                 was_limited_o;
  logic                 written_o;

  int   fail_cnt;
  int   outstanding;
  int   cycle_cnt = 0;
  logic src_gaps;
  logic snk_gaps;

  servo_sine_oscillator_slew_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .target_angle_i (target_angle_i),
    .elapsed_ms_i   (elapsed_ms_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .servo_angle_o  (servo_angle_o),
    .was_limited_o  (was_limited_o),
    .written_o      (written_o)
  );

  servo_slew_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .kind_i         (kind_i),
    .target_angle_i (target_angle_i),
    .elapsed_ms_i   (elapsed_ms_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .servo_angle_i  (servo_angle_o),
    .was_limited_i  (was_limited_o),
    .written_i      (written_o),
    .fail_cnt_o     (fail_cnt),
    .outstanding_o  (outstanding)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("** servo_sine_oscillator_slew_top: FAILED **");
      $finish;
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // one command transaction; valid stays up across back-to-back commands
  task automatic send_command(input servo_cmd_e k, input logic [7:0] t,
                              input logic [15:0] ms);
    int gap;
    gap = src_gaps ? $urandom_range(0, 11) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= k;
    target_angle_i <= t;
    elapsed_ms_i   <= ms;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // stop sending and let every result come back
  task automatic wait_settled();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic load_random_setup();
    logic [15:0] v;
    case ($urandom_range(0, 4))
      0:       v = 16'd0;
      1:       v = 16'd90;
      2:       v = 16'd127;
      default: v = 16'($urandom_range(0, 127));
    endcase
    write_reg(CFG_AMPLITUDE, v);
    write_reg(CFG_PHASE_OFFSET, 16'($urandom));
    case ($urandom_range(0, 4))
      0:       v = 16'd0;
      1:       v = 16'hFFFF;
      2:       v = 16'($urandom_range(1, 64));
      default: v = 16'($urandom);
    endcase
    write_reg(CFG_PHASE_STEP, v);
    case ($urandom_range(0, 5))
      0:       v = 16'd0;
      1:       v = 16'd1;
      2:       v = 16'd1000;
      3:       v = 16'd1023;
      default: v = 16'($urandom_range(0, 1023));
    endcase
    write_reg(CFG_SLEW_RATE, v);
    write_reg(CFG_STOPPED, 16'($urandom_range(0, 3) == 0));
  endtask

  function automatic logic [15:0] pick_elapsed();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(0, 3));
      1:       return 16'($urandom_range(0, 200));
      2:       return 16'($urandom_range(0, 2000));
      default: return 16'($urandom);
    endcase
  endfunction

  // receiver: random stall before each result
  initial begin
    int stall;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = snk_gaps ? $urandom_range(0, 11) : 0;
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    logic [7:0] t;
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_AMPLITUDE;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    kind_i         = CMD_TICK;
    target_angle_i = '0;
    elapsed_ms_i   = '0;
    src_gaps       = 1'b1;
    snk_gaps       = 1'b1;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset setup: zero amplitude, limiter off, targets beyond full scale
    send_command(CMD_TICK, 8'd0, 16'd0);
    send_command(CMD_TICK, 8'hFF, 16'hFFFF);
    send_command(CMD_SET, 8'd0, 16'd0);
    send_command(CMD_SET, 8'd180, 16'd1);
    send_command(CMD_SET, 8'd255, 16'd0);
    send_command(CMD_SET, 8'd181, 16'h5555);

    // quarter-turn steps hit both peaks; max amplitude overshoots both ends
    wait_settled();
    write_reg(CFG_AMPLITUDE, 16'd127);
    write_reg(CFG_PHASE_STEP, 16'd16384);
    src_gaps = 1'b0;
    repeat (4) send_command(CMD_TICK, 8'd0, 16'd0);

    // fastest limiter: minimum bound of one degree, and saturated bound
    wait_settled();
    write_reg(CFG_AMPLITUDE, 16'd90);
    write_reg(CFG_PHASE_OFFSET, 16'hFFFF);
    write_reg(CFG_PHASE_STEP, 16'hFFFF);
    write_reg(CFG_SLEW_RATE, 16'd1023);
    src_gaps = 1'b1;
    send_command(CMD_SET, 8'd0, 16'd0);
    send_command(CMD_SET, 8'd180, 16'hFFFF);
    send_command(CMD_TICK, 8'd0, 16'd1);
    send_command(CMD_TICK, 8'd0, 16'd999);
    send_command(CMD_SET, 8'd90, 16'hAAAA);

    // stopped ticks hold the angle; slowest nonzero rate
    wait_settled();
    write_reg(CFG_SLEW_RATE, 16'd1);
    write_reg(CFG_STOPPED, 16'd1);
    send_command(CMD_TICK, 8'd0, 16'hFFFF);
    send_command(CMD_TICK, 8'd77, 16'hFFFF);
    send_command(CMD_SET, 8'd0, 16'hFFFF);
    send_command(CMD_SET, 8'd180, 16'd1000);

    wait_settled();
    write_reg(CFG_STOPPED, 16'd0);
    write_reg(CFG_SLEW_RATE, 16'd1000);
    write_reg(CFG_AMPLITUDE, 16'd45);
    write_reg(CFG_PHASE_OFFSET, 16'd8192);
    write_reg(CFG_PHASE_STEP, 16'd0);
    send_command(CMD_TICK, 8'd0, 16'd0);
    send_command(CMD_TICK, 8'd0, 16'd0);
    send_command(CMD_SET, 8'd200, 16'd500);

    for (int ph = 0; ph < 15; ph++) begin
      wait_settled();
      load_random_setup();
      src_gaps = ($urandom_range(0, 2) != 0);
      snk_gaps = ($urandom_range(0, 2) != 0);
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(0, 63) == 0) begin
          wait_settled();
        end
        t = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 180))
                                        : 8'($urandom_range(0, 255));
        send_command(servo_cmd_e'($urandom_range(0, 1)), t, pick_elapsed());
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (fail_cnt == 0) begin
      $display("** servo_sine_oscillator_slew_top: PASSED **");
    end else begin
      $display("** servo_sine_oscillator_slew_top: FAILED **");
    end
    $finish;
  end

endmodule
